@@ rtl/core/ntc_pkg.sv @@
// ============================================================================
// ntc_pkg
// Shared constants, status codes and the resistance curve for the NTC
// temperature core.
// ============================================================================
package ntc_pkg;

   localparam int TableLength = 156;
   localparam int MinTempC    = -30;
   localparam int FracBits    = 8;
   localparam int IdxW        = $clog2(TableLength);

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SHORT = 2'd1;
   localparam logic [1:0] STATUS_OPEN  = 2'd2;
   localparam logic [1:0] STATUS_UNCFG = 2'd3;

   localparam logic [1:0] CSR_FULL_SCALE = 2'd0;
   localparam logic [1:0] CSR_ADC_BITS   = 2'd1;
   localparam logic [1:0] CSR_UPPER_RES  = 2'd2;
   localparam logic [1:0] CSR_LOWER_RES  = 2'd3;

   localparam logic [17:0] RES_OUT_MAX = 18'h3FFFF;

   typedef logic [17:0] curve_entry_type;

   function automatic curve_entry_type curve_rom(input logic [IdxW-1:0] idx);
      curve_entry_type t [0:TableLength-1];
      t = '{
         135452, 127837, 120707, 114028, 107768, 101898, 96391, 91222, 86369, 81809,
         77523, 73492, 69701, 66132, 62771, 59606, 56623, 53810, 51157, 48654,
         46290, 44058, 41950, 39957, 38072, 36290, 34603, 33006, 31494, 30062,
         28704, 27417, 26197, 25039, 23940, 22897, 21906, 20964, 20070, 19219,
         18410, 17641, 16909, 16212, 15548, 14916, 14313, 13739, 13192, 12669,
         12171, 11696, 11242, 10809, 10395, 10000, 9622, 9261, 8916, 8585,
         8269, 7967, 7678, 7400, 7135, 6881, 6637, 6403, 6179, 5965,
         5759, 5561, 5372, 5189, 5015, 4847, 4686, 4531, 4382, 4239,
         4101, 3969, 3842, 3719, 3601, 3488, 3379, 3274, 3172, 3075,
         2981, 2890, 2803, 2719, 2638, 2559, 2484, 2411, 2341, 2273,
         2207, 2144, 2083, 2024, 1967, 1912, 1858, 1807, 1757, 1709,
         1662, 1617, 1574, 1532, 1491, 1451, 1413, 1376, 1340, 1305,
         1272, 1239, 1208, 1177, 1147, 1118, 1091, 1063, 1037, 1012,
         987, 963, 940, 917, 895, 874, 853, 833, 814, 795,
         776, 758, 741, 724, 708, 692, 676, 661, 646, 632,
         618, 604, 591, 578, 566, 554
      };
      if (int'(idx) < TableLength) begin
         return t[idx];
      end
      return t[TableLength-1];
   endfunction

endpackage

@@ rtl/core/ntc_adc_to_temperature_core.sv @@
// ============================================================================
// ntc_adc_to_temperature_core
// ADC sample to thermistor resistance and temperature, using one shared
// restoring divider and a sequential curve search.
// ============================================================================
//  channel | ports                                   | handshake
//  request | req_adc_sample                          | start & !busy
//  result  | rsp_temperature_tenths, rsp_resistance_ohms, rsp_status | rsp_valid, 1 cycle
//  config  | csr_we, csr_index, csr_wdata            | csr_we
//
// Order: a zero, unconfigured or over-range sample goes from the check to the
// result, a bad divider ends after the products, a resistance outside the curve
// after the resistance division and fraction bits; else the products, resistance
// division, fraction bits, range check, curve search and interpolation division
// run in turn. The shared 20x20 multiplier, the one-bit-a-cycle divider and the
// one-entry-a-cycle curve scan set the pace. busy drops in the result cycle.
// Reset is synchronous and sets only the state, result strobe and configuration
// registers. The result is presented once; the receiver cannot stall it.
module ntc_adc_to_temperature_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [15:0]          req_adc_sample,
   output logic                 rsp_valid,
   output logic signed [11:0]   rsp_temperature_tenths,
   output logic [17:0]          rsp_resistance_ohms,
   output logic [1:0]           rsp_status,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [19:0]          csr_wdata
);
   import ntc_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CHECK  = 4'd1;
   localparam logic [3:0] ST_MUL_A  = 4'd2;
   localparam logic [3:0] ST_MUL_B  = 4'd3;
   localparam logic [3:0] ST_MUL_N  = 4'd4;
   localparam logic [3:0] ST_DEN    = 4'd5;
   localparam logic [3:0] ST_DIV    = 4'd6;
   localparam logic [3:0] ST_RANGE  = 4'd7;
   localparam logic [3:0] ST_SEARCH = 4'd8;
   localparam logic [3:0] ST_FSET   = 4'd9;
   localparam logic [3:0] ST_FDIV   = 4'd10;
   localparam logic [3:0] ST_DONE   = 4'd11;
   localparam logic [3:0] ST_MUL_H  = 4'd12;

   // divider: 56-bit numerator (the full ra*rb*adc product), 40-bit divisor
   localparam int NumW = 56;
   localparam int DenW = 40;
   localparam int RqW  = 41 + FracBits;

   logic [3:0]        state_ff, state_in;
   logic [15:0]       fs_ff;
   logic [4:0]        bits_ff;
   logic [19:0]       ra_ff, rb_ff;
   logic [15:0]       adc_ff, adc_in;
   logic [DenW-1:0]   a_ff, a_in, b_ff, b_in;
   logic [NumW-1:0]   num_ff, num_in;
   logic [DenW:0]     rem_ff, rem_in;
   logic [DenW-1:0]   den_ff, den_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [RqW-1:0]    rq_ff, rq_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic signed [11:0] temp_ff, temp_in;
   logic [17:0]       res_ff, res_in;
   logic [1:0]        stat_ff, stat_in;

   logic [DenW:0]     rem_sh;
   logic              q_bit;
   logic [39:0]       mul_p;
   logic [19:0]       mul_x, mul_y;
   logic [RqW-1:0]    e_cur, e_nxt;
   logic [17:0]       ipart_sat;
   logic signed [11:0] base_t;

   assign mul_p  = 40'(mul_x) * 40'(mul_y);
   assign rem_sh = {rem_ff[DenW-1:0], num_ff[NumW-1]};
   assign q_bit  = rem_sh >= {1'b0, den_ff};
   assign e_cur  = RqW'(curve_rom(idx_ff)) << FracBits;
   assign e_nxt  = RqW'(curve_rom(idx_ff + 1'b1)) << FracBits;
   assign ipart_sat = (rq_ff[RqW-1:FracBits] > (RqW-FracBits)'(RES_OUT_MAX)) ?
                      RES_OUT_MAX : rq_ff[FracBits+17:FracBits];
   assign base_t = 12'(10 * (MinTempC + int'(idx_ff)));

   always_comb begin
      mul_x = ra_ff;
      mul_y = 20'(fs_ff - adc_ff);
      unique case (state_ff)
         ST_MUL_B: begin mul_x = rb_ff; mul_y = 20'(adc_ff); end
         ST_MUL_N: begin mul_x = ra_ff; mul_y = b_ff[19:0]; end
         ST_MUL_H: begin mul_x = ra_ff; mul_y = {4'd0, b_ff[35:20]}; end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      adc_in = adc_ff; a_in = a_ff; b_in = b_ff; num_in = num_ff;
      rem_in = rem_ff; den_in = den_ff; cnt_in = cnt_ff; rq_in = rq_ff;
      idx_in = idx_ff; valid_in = 1'b0;
      temp_in = temp_ff; res_in = res_ff; stat_in = stat_ff;
      unique case (state_ff)
         ST_IDLE: if (start) begin
            adc_in = req_adc_sample; state_in = ST_CHECK;
         end
         ST_CHECK: begin
            temp_in = '0; res_in = '0; state_in = ST_DONE;
            priority if (adc_ff == '0) stat_in = STATUS_SHORT;
            else if (fs_ff == '0 || bits_ff == '0) stat_in = STATUS_UNCFG;
            else if (fs_ff <= adc_ff) stat_in = STATUS_OPEN;
            else state_in = ST_MUL_A;
         end
         ST_MUL_A: begin a_in = mul_p; state_in = ST_MUL_B; end
         ST_MUL_B: begin b_in = mul_p; state_in = ST_MUL_N; end
         // num = ra*rb*adc as ra*b, low and high halves of b
         ST_MUL_N: begin num_in = NumW'(mul_p); state_in = ST_MUL_H; end
         ST_MUL_H: begin
            num_in = num_ff + (NumW'(mul_p) << 20); state_in = ST_DEN;
         end
         ST_DEN: begin
            if (a_ff <= b_ff) begin
               stat_in = STATUS_OPEN; state_in = ST_DONE;
            end else begin
               den_in = a_ff - b_ff; rem_in = '0; cnt_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // 56 integer quotient bits
            rem_in = q_bit ? rem_sh - {1'b0, den_ff} : rem_sh;
            num_in = {num_ff[NumW-2:0], q_bit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(NumW-1)) begin
               cnt_in = '0; state_in = ST_RANGE;
               // clamp then continue fraction bits
               if ({num_ff[NumW-2:0], q_bit} > (NumW'(1) << 40)) begin
                  rq_in = RqW'(1) << 40; rem_in = '0;
               end else begin
                  rq_in = RqW'({num_ff[NumW-2:0], q_bit});
               end
               state_in = ST_FSET;
               idx_in = '0;
               num_in = '0;
               cnt_in = 6'(FracBits);
            end
         end
         ST_FSET: begin
            // fraction bits of R, one per cycle; num is zero here
            if (cnt_ff != '0) begin
               rem_in = q_bit ? rem_sh - {1'b0, den_ff} : rem_sh;
               rq_in = {rq_ff[RqW-2:0], q_bit};
               cnt_in = cnt_ff - 1'b1;
            end else begin
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            res_in = ipart_sat; temp_in = '0;
            priority if (rq_ff > (RqW'(curve_rom('0)) << FracBits)) begin
               stat_in = STATUS_OPEN; state_in = ST_DONE;
            end else if (rq_ff < (RqW'(curve_rom(IdxW'(TableLength-1))) << FracBits)) begin
               stat_in = STATUS_SHORT; state_in = ST_DONE;
            end else begin
               idx_in = '0; state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if ((rq_ff > e_nxt && rq_ff <= e_cur) ||
                idx_ff == IdxW'(TableLength-2)) begin
               // fnum = 10*(e_cur-rq), seg = (e_cur-e_nxt); fnum <= 10*seg
               num_in = NumW'(((e_cur - rq_ff) << 3) + ((e_cur - rq_ff) << 1))
                        << (NumW-32);
               den_in = DenW'(e_cur - e_nxt);
               rem_in = '0; cnt_in = '0; state_in = ST_FDIV;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FDIV: begin
            rem_in = q_bit ? rem_sh - {1'b0, den_ff} : rem_sh;
            num_in = {num_ff[NumW-2:0], q_bit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd31) begin
               stat_in = STATUS_OK;
               if (den_ff == '0) begin
                  temp_in = base_t;
               end else begin
                  temp_in = base_t + 12'({num_ff[NumW-2:0], q_bit} & 56'hFFFF)
                     + ((base_t < 0 && (q_bit ? rem_sh - {1'b0, den_ff} : rem_sh) != '0)
                        ? 12'sd1 : 12'sd0);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin valid_in = 1'b1; state_in = ST_IDLE; end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         fs_ff <= 16'd4095; bits_ff <= 5'd12;
         ra_ff <= 20'd390000; rb_ff <= 20'd4700;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FULL_SCALE: fs_ff   <= csr_wdata[15:0];
               CSR_ADC_BITS:   bits_ff <= csr_wdata[4:0];
               CSR_UPPER_RES:  ra_ff   <= csr_wdata;
               CSR_LOWER_RES:  rb_ff   <= csr_wdata;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      adc_ff <= adc_in; a_ff <= a_in; b_ff <= b_in; num_ff <= num_in;
      rem_ff <= rem_in; den_ff <= den_in; cnt_ff <= cnt_in; rq_ff <= rq_in;
      idx_ff <= idx_in; temp_ff <= temp_in; res_ff <= res_in; stat_ff <= stat_in;
   end

   assign busy = state_ff != ST_IDLE;
   assign rsp_valid = valid_ff;
   assign rsp_temperature_tenths = temp_ff;
   assign rsp_resistance_ohms = res_ff;
   assign rsp_status = stat_ff;

   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid) else $error("missing result");
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_ok_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_temperature_tenths == '0)
      else $error("error with temperature");
endmodule
